/* rtl/core/mbp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbp_pkg: shared types and constants of the MSB bit packer
// Field widths, stuffing codes, chunk format and queue sizing.
// ---------------------------------------------------------------------------
package mbp_pkg;

    localparam int MAX_CODE_BITS = 24;
    localparam int BYTE_W        = 8;
    localparam int CODE_W        = 24;
    localparam int COUNT_W       = 5;
    localparam int PEND_W        = 7;
    localparam int PCNT_W        = 3;
    localparam int WIN_W         = 32;
    localparam int CHUNK_BYTES   = 3;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = 2;
    localparam int QCNT_W        = 3;

    localparam logic [BYTE_W-1:0] STUFF_TRIGGER = 8'hFF;
    localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'h00;

    typedef enum logic {
        KIND_APPEND = 1'b0,
        KIND_FLUSH  = 1'b1
    } t_kind;

    // Byte slots of one chunk, slot 0 goes out first
    typedef enum logic [1:0] {
        SLOT_0 = 2'd0,
        SLOT_1 = 2'd1,
        SLOT_2 = 2'd2
    } t_slot;

    // Completed bytes produced by one transaction
    typedef struct packed {
        logic [CHUNK_BYTES-1:0][BYTE_W-1:0] data;
        logic [1:0]                         nbytes;
    } t_chunk;

endpackage

/* rtl/core/msb_bit_packer_byte_stuff_top.sv */
`timescale 1ns / 1ps
// An accepted transaction reaches o_valid through the chunk queue and the output register.
// Throughput: one output byte per cycle while i_stall is low; every byte of a
//   transaction, stuffed zeros included, goes out through the byte emitter.
// Input accepts one transaction per cycle while the 4-entry chunk queue has room.
// Reset: synchronous active low, clears pending bits, queue and output valid.
// ---------------------------------------------------------------------------
// msb_bit_packer_byte_stuff_top: MSB-first bit packer with 0xFF stuffing
// Merger front, chunk queue and byte emitter back.
// ---------------------------------------------------------------------------
module msb_bit_packer_byte_stuff_top
    import mbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_kind,
    input  logic [CODE_W-1:0]  i_code_value,
    input  logic [COUNT_W-1:0] i_bit_count,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_last
);

    logic   push, pop, full, empty;
    t_chunk push_chunk, head_chunk;

    // Merge codes into byte chunks
    mbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_kind       (i_kind),
        .i_code_value (i_code_value),
        .i_bit_count  (i_bit_count),
        .i_full       (full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_chunk      (push_chunk)
    );

    // Decouple merger and emitter
    mbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_chunk (push_chunk),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_chunk (head_chunk)
    );

    // Emit bytes with stuffing
    mbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_chunk    (head_chunk),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

/* rtl/core/mbp_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbp_front: bit merger
// Appends each code after the pending bits, cuts complete bytes into a
// chunk for the queue and keeps the remaining partial byte; a flush pads it with ones.
// ---------------------------------------------------------------------------
module mbp_front
    import mbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_kind,
    input  logic [CODE_W-1:0]  i_code_value,
    input  logic [COUNT_W-1:0] i_bit_count,
    input  logic               i_full,
    output logic               o_stall,
    output logic               o_push,
    output t_chunk             o_chunk
);

    logic [PEND_W-1:0]  r_pbits, n_pbits;
    logic [PCNT_W-1:0]  r_pcnt,  n_pcnt;

    logic               accept;
    t_kind              kind;
    logic [COUNT_W-1:0] cnt;
    logic [WIN_W-1:0]   code_left;
    logic [WIN_W-1:0]   pend_left;
    logic [WIN_W-1:0]   window;
    logic [COUNT_W-1:0] total;
    logic [WIN_W-1:0]   tail;
    logic [PEND_W-1:0]  tail_mask;
    logic [BYTE_W-1:0]  flush_byte;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign kind    = t_kind'(i_kind);

    // Saturate the count and left-align code and pending bits in one window
    always_comb begin
        cnt       = (i_bit_count > COUNT_W'(MAX_CODE_BITS)) ?
                    COUNT_W'(MAX_CODE_BITS) : i_bit_count;
        code_left = {i_code_value, {(WIN_W-CODE_W){1'b0}}}
                    << (6'(CODE_W) - {1'b0, cnt});
        pend_left = {r_pbits, {(WIN_W-PEND_W){1'b0}}}
                    << (PCNT_W'(PEND_W) - r_pcnt);
        window    = pend_left | (code_left >> r_pcnt);
        total     = COUNT_W'(r_pcnt) + cnt;
        tail      = window >> (6'(WIN_W) - {1'b0, total});
        tail_mask = 7'h7F >> (PCNT_W'(PEND_W) - total[PCNT_W-1:0]);
        flush_byte = (BYTE_W'({1'b0, r_pbits}) << (4'(BYTE_W) - {1'b0, r_pcnt}))
                     | (8'hFF >> r_pcnt);
    end

    // Build the chunk and next pending state
    always_comb begin
        o_chunk = '0;
        n_pbits = r_pbits;
        n_pcnt  = r_pcnt;
        unique case (kind)
            KIND_FLUSH: begin
                o_chunk.data[0] = flush_byte;
                o_chunk.nbytes  = (r_pcnt != '0) ? 2'd1 : 2'd0;
                n_pbits         = '0;
                n_pcnt          = '0;
            end
            default: begin
                o_chunk.data[0] = window[WIN_W-1 -: BYTE_W];
                o_chunk.data[1] = window[WIN_W-1-BYTE_W -: BYTE_W];
                o_chunk.data[2] = window[WIN_W-1-2*BYTE_W -: BYTE_W];
                o_chunk.nbytes  = total[COUNT_W-1:PCNT_W];
                n_pbits         = tail[PEND_W-1:0] & tail_mask;
                n_pcnt          = total[PCNT_W-1:0];
            end
        endcase
        o_push = accept && (o_chunk.nbytes != 2'd0);
    end

    // Hold pending bits, update on every transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits <= '0;
            r_pcnt  <= '0;
        end else if (accept) begin
            r_pbits <= n_pbits;
            r_pcnt  <= n_pcnt;
        end
    end

endmodule

/* rtl/core/mbp_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbp_queue: chunk queue
// Small circular buffer of byte chunks between merger and emitter.
// ---------------------------------------------------------------------------
module mbp_queue
    import mbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_chunk i_chunk,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_chunk o_chunk
);

    t_chunk              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_chunk = r_mem[r_rd];

    // Store pushed chunks
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_chunk;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("chunk pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("chunk popped from empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + QCNT_W'(1)))
        else $error("fill count did not track push");
`endif

endmodule

/* rtl/core/mbp_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbp_back: byte emitter
// Walks the bytes of each queued chunk, inserts a zero byte after every
// 0xFF and marks the final byte of each transaction.
// ---------------------------------------------------------------------------
module mbp_back
    import mbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_chunk            i_chunk,
    input  logic              i_stall,
    output logic              o_pop,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last
);

    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_byte,  n_byte;
    logic              r_last,  n_last;
    t_slot             r_idx,   n_idx;
    logic              r_stuff, n_stuff;
    logic              r_stuff_last, n_stuff_last;

    logic              load;
    logic [BYTE_W-1:0] head_byte;
    logic              head_final;

    assign load = !r_valid || !i_stall;

    // Select the current byte of the head chunk
    always_comb begin
        unique case (r_idx)
            SLOT_0:  head_byte = i_chunk.data[0];
            SLOT_1:  head_byte = i_chunk.data[1];
            SLOT_2:  head_byte = i_chunk.data[2];
            default: head_byte = i_chunk.data[0];
        endcase
        head_final = ({1'b0, r_idx} + 3'd1) == {1'b0, i_chunk.nbytes};
    end

    // Pick the next output: stuffed zero first, then chunk bytes
    always_comb begin
        n_valid      = r_valid;
        n_byte       = r_byte;
        n_last       = r_last;
        n_idx        = r_idx;
        n_stuff      = r_stuff;
        n_stuff_last = r_stuff_last;
        o_pop        = 1'b0;
        if (load) begin
            priority if (r_stuff) begin
                n_valid = 1'b1;
                n_byte  = STUFF_BYTE;
                n_last  = r_stuff_last;
                n_stuff = 1'b0;
            end else if (!i_empty) begin
                n_valid      = 1'b1;
                n_byte       = head_byte;
                n_stuff      = (head_byte == STUFF_TRIGGER);
                n_stuff_last = head_final;
                n_last       = head_final && (head_byte != STUFF_TRIGGER);
                if (head_final) begin
                    o_pop = 1'b1;
                    n_idx = SLOT_0;
                end else begin
                    n_idx = t_slot'(r_idx + 2'd1);
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // Hold control state; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_idx        <= SLOT_0;
            r_stuff      <= 1'b0;
            r_stuff_last <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_idx        <= n_idx;
            r_stuff      <= n_stuff;
            r_stuff_last <= n_stuff_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

`ifndef SYNTH
    a_stuff_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_out_byte == STUFF_TRIGGER)
        |=> (o_valid && o_out_byte == STUFF_BYTE))
        else $error("0xFF not followed by stuffed zero");
    a_ff_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_byte == STUFF_TRIGGER) |-> !o_last)
        else $error("0xFF marked as final byte");
    a_pop_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == SLOT_0))
        else $error("slot index not rewound after pop");
`endif

endmodule
